FILE: sv/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Shared constants, register indexes and item types of the Sobel edge
// detector.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 12;
  localparam int THR_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
  localparam logic [THR_W-1:0] THR_RESET    = THR_W'(80);

  // Queue between the window front and the arithmetic back.
  localparam int WQ_DEPTH = 4;
  localparam int WQ_AW    = $clog2(WQ_DEPTH);
  // Result queue at the output.
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  // The eight window taps that the two kernels use, plus the frame flag.
  typedef struct packed {
    pix_t ul;
    pix_t ml;
    pix_t bl;
    pix_t um;
    pix_t bm;
    pix_t up;
    pix_t mid;
    pix_t bot;
    logic frame_last;
  } win_t;

  typedef struct packed {
    pix_t grad_x;
    pix_t grad_y;
    logic edge_res;
    logic frame_end;
  } res_t;

endpackage

FILE: sv/sed_front.sv
// ----------------------------------------------------------------------------
// sed_front
// Raster counters, the two line stores and the 3x3 window. Classifies each
// pixel as border or interior and queues the window of interior items.
// ----------------------------------------------------------------------------
module sed_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [sed_pkg::DIM_W-1:0]  image_width,
  input  logic [sed_pkg::DIM_W-1:0]  image_height,
  input  logic                       in_push,
  input  sed_pkg::pix_t              in_pixel,
  output logic                       in_full,
  output logic                       wq_push,
  output sed_pkg::win_t              wq_data,
  input  logic                       wq_full
);
  import sed_pkg::*;

  localparam int EXT_W = ((DIM_W > COL_W) ? DIM_W : COL_W) + 1;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last_idx;
  logic             row_last;
  logic             frame_last;
  logic             acc;

  logic             s1_valid_r;
  logic             s1_emit_r;
  logic             s1_flast_r;
  logic [COL_W-1:0] s1_addr_r;
  pix_t             s1_pix_r;
  pix_t             up_rd_r;
  pix_t             mid_rd_r;
  logic             s1_adv;

  pix_t row_store_upper_r  [MAX_WIDTH];
  pix_t row_store_middle_r [MAX_WIDTH];
  pix_t win_r [6];

  // Index of the last column or row: the size clamped to 3..max, minus one.
  function automatic logic [EXT_W-1:0] last_idx(input logic [DIM_W-1:0] v,
                                                 input logic [EXT_W-1:0] hi);
    logic [EXT_W-1:0] ve;
    begin
      ve = EXT_W'(v);
      if (ve < EXT_W'(3)) begin
        last_idx = EXT_W'(2);
      end else if (ve > hi) begin
        last_idx = hi - EXT_W'(1);
      end else begin
        last_idx = ve - EXT_W'(1);
      end
    end
  endfunction

  always_comb begin
    col_last     = COL_W'(last_idx(image_width, EXT_W'(MAX_WIDTH)));
    row_last_idx = ROW_W'(last_idx(image_height, EXT_W'(MAX_HEIGHT)));
    row_last     = (col_r >= col_last);
    frame_last   = row_last && (row_r >= row_last_idx);
    s1_adv       = s1_valid_r && (!s1_emit_r || !wq_full);
    in_full      = s1_valid_r && !s1_adv;
    acc          = in_push && !in_full;
    col_nxt      = col_r;
    row_nxt      = row_r;
    if (acc) begin
      if (row_last) begin
        col_nxt = '0;
        row_nxt = frame_last ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r   <= in_pixel;
      s1_addr_r  <= col_r;
      s1_emit_r  <= (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
      s1_flast_r <= frame_last;
    end
  end

  // The line stores are read when an item is taken and written when it
  // leaves stage one; the next access to the same column is a row later.
  always_ff @(posedge clk) begin
    if (acc) begin
      up_rd_r  <= row_store_upper_r[col_r];
      mid_rd_r <= row_store_middle_r[col_r];
    end
    if (s1_adv) begin
      row_store_upper_r[s1_addr_r]  <= mid_rd_r;
      row_store_middle_r[s1_addr_r] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= up_rd_r;
      win_r[4] <= mid_rd_r;
      win_r[5] <= s1_pix_r;
    end
  end

  always_comb begin
    wq_push            = s1_adv && s1_emit_r;
    wq_data.ul         = win_r[0];
    wq_data.ml         = win_r[1];
    wq_data.bl         = win_r[2];
    wq_data.um         = win_r[3];
    wq_data.bm         = win_r[5];
    wq_data.up         = up_rd_r;
    wq_data.mid        = mid_rd_r;
    wq_data.bot        = s1_pix_r;
    wq_data.frame_last = s1_flast_r;
  end

  // A stalled item must keep the line-store data it read.
  a_stall_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> ($stable(up_rd_r) && $stable(mid_rd_r)))
    else $error("line store read data changed under a stalled item");

  // The window is never pushed into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    wq_push |-> !wq_full)
    else $error("window pushed into full queue");

endmodule

FILE: sv/sed_win_fifo.sv
// ----------------------------------------------------------------------------
// sed_win_fifo
// Short queue of windows between the front and the arithmetic back.
// ----------------------------------------------------------------------------
module sed_win_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sed_pkg::win_t din,
  output logic          full,
  input  logic          pop,
  output sed_pkg::win_t dout,
  output logic          empty
);
  import sed_pkg::*;

  win_t             mem_r [WQ_DEPTH];
  logic [WQ_AW-1:0] wr_ptr_r;
  logic [WQ_AW-1:0] rd_ptr_r;
  logic [WQ_AW:0]   count_r;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    full    = (count_r == (WQ_AW + 1)'(WQ_DEPTH));
    empty   = (count_r == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    dout    = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + WQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + WQ_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (WQ_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (WQ_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (WQ_AW + 1)'(WQ_DEPTH))
    else $error("window queue count beyond depth");

endmodule

FILE: sv/sed_back.sv
// ----------------------------------------------------------------------------
// sed_back
// Sobel sums, clamping, squared magnitude against the squared threshold, and
// the result queue. Windows are taken only when the result queue has room
// for everything already in flight.
// ----------------------------------------------------------------------------
module sed_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [sed_pkg::THR_W-1:0] edge_threshold,
  input  logic                      wq_empty,
  input  sed_pkg::win_t             wq_dout,
  output logic                      wq_pop,
  output logic                      out_empty,
  input  logic                      out_pop,
  output sed_pkg::pix_t             out_grad_x,
  output sed_pkg::pix_t             out_grad_y,
  output logic                      out_edge_res,
  output logic                      out_frame_end
);
  import sed_pkg::*;

  localparam int SUM_W = PIX_W + 3;
  localparam int SQ_W  = 2 * PIX_W;
  localparam int T2_W  = 2 * THR_W;

  logic [T2_W-1:0]  t2_r;

  logic             va_r;
  pix_t             gx_a_r;
  pix_t             gy_a_r;
  logic             fl_a_r;

  // Stage B also keeps the clamped sums for the result fields.
  logic             vb_r;
  logic [SQ_W-1:0]  sqx_r;
  logic [SQ_W-1:0]  sqy_r;
  pix_t             gx_b_r;
  pix_t             gy_b_r;
  logic             fl_b_r;

  logic signed [SUM_W-1:0] sx;
  logic signed [SUM_W-1:0] sy;
  logic [SQ_W:0]           mag2;
  res_t                    res;

  res_t             oq_mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr_r;
  logic [OQ_AW-1:0] oq_rd_r;
  logic [OQ_AW:0]   oq_count_r;
  logic [OQ_AW+1:0] committed;
  logic             oq_pop;

  function automatic logic signed [SUM_W-1:0] ext(input pix_t p);
    ext = $signed({{(SUM_W - PIX_W){1'b0}}, p});
  endfunction

  function automatic pix_t clamp_sum(input logic signed [SUM_W-1:0] s);
    if (s[SUM_W-1]) begin
      clamp_sum = '0;
    end else if (s > ext(8'd255)) begin
      clamp_sum = 8'd255;
    end else begin
      clamp_sum = s[PIX_W-1:0];
    end
  endfunction

  always_comb begin
    committed = (OQ_AW + 2)'(oq_count_r) + (OQ_AW + 2)'(va_r) + (OQ_AW + 2)'(vb_r);
    wq_pop    = !wq_empty && (committed < (OQ_AW + 2)'(OQ_DEPTH));
    sx = (ext(wq_dout.up) - ext(wq_dout.ul))
       + ((ext(wq_dout.mid) - ext(wq_dout.ml)) <<< 1)
       + (ext(wq_dout.bot) - ext(wq_dout.bl));
    sy = (ext(wq_dout.bl) + (ext(wq_dout.bm) <<< 1) + ext(wq_dout.bot))
       - (ext(wq_dout.ul) + (ext(wq_dout.um) <<< 1) + ext(wq_dout.up));
    mag2          = {1'b0, sqx_r} + {1'b0, sqy_r};
    res.grad_x    = gx_b_r;
    res.grad_y    = gy_b_r;
    res.edge_res  = (T2_W'(mag2) > t2_r);
    res.frame_end = fl_b_r;
  end

  always_ff @(posedge clk) begin
    t2_r <= T2_W'(edge_threshold) * T2_W'(edge_threshold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= wq_pop;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wq_pop) begin
      gx_a_r <= clamp_sum(sx);
      gy_a_r <= clamp_sum(sy);
      fl_a_r <= wq_dout.frame_last;
    end
    if (va_r) begin
      sqx_r  <= gx_a_r * gx_a_r;
      sqy_r  <= gy_a_r * gy_a_r;
      gx_b_r <= gx_a_r;
      gy_b_r <= gy_a_r;
      fl_b_r <= fl_a_r;
    end
  end

  // Result queue.
  always_comb begin
    out_empty     = (oq_count_r == '0);
    oq_pop        = out_pop && !out_empty;
    out_grad_x    = oq_mem_r[oq_rd_r].grad_x;
    out_grad_y    = oq_mem_r[oq_rd_r].grad_y;
    out_edge_res  = oq_mem_r[oq_rd_r].edge_res;
    out_frame_end = oq_mem_r[oq_rd_r].frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r    <= '0;
      oq_rd_r    <= '0;
      oq_count_r <= '0;
    end else begin
      if (vb_r) begin
        oq_wr_r <= oq_wr_r + OQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + OQ_AW'(1);
      end
      if (vb_r && !oq_pop) begin
        oq_count_r <= oq_count_r + (OQ_AW + 1)'(1);
      end else if (oq_pop && !vb_r) begin
        oq_count_r <= oq_count_r - (OQ_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vb_r) begin
      oq_mem_r[oq_wr_r] <= res;
    end
  end

  // Items in flight plus queued results never outnumber the queue slots.
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    committed <= (OQ_AW + 2)'(OQ_DEPTH))
    else $error("result queue overcommitted");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r |-> (oq_count_r < (OQ_AW + 1)'(OQ_DEPTH)))
    else $error("result written into full queue");

  a_pop_feeds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    wq_pop |=> ##1 vb_r)
    else $error("window lost in arithmetic stages");

endmodule

FILE: sv/sobel_edge_detector.sv
// Path to the out_ ports: the pixel completing its 3x3 window passes the input
// stage register, the window queue, stages A and B and the result queue.
// Throughput: one pixel per clock while no queue backs up; the line stores take
// one read and one write per cycle and the arithmetic back is fully pipelined.
// Reset (synchronous, active low) empties all queues, zeroes the counters and
// window, and loads width 640, height 480, threshold 80; line stores keep data.
// ----------------------------------------------------------------------------
// sobel_edge_detector
// Streaming 3x3 Sobel edge detector on 8-bit grayscale pixels in raster
// order, with queue-style input and result channels.
// ----------------------------------------------------------------------------
module sobel_edge_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sed_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sed_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_push,
  input  logic [sed_pkg::PIX_W-1:0]      in_pixel,
  output logic                           in_full,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [sed_pkg::PIX_W-1:0]      out_grad_x,
  output logic [sed_pkg::PIX_W-1:0]      out_grad_y,
  output logic                           out_edge_res,
  output logic                           out_frame_end
);
  import sed_pkg::*;

  logic [DIM_W-1:0] image_width_r;
  logic [DIM_W-1:0] image_height_r;
  logic [THR_W-1:0] edge_threshold_r;

  logic wq_push;
  logic wq_full;
  logic wq_pop;
  logic wq_empty;
  win_t wq_din;
  win_t wq_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r    <= WIDTH_RESET;
      image_height_r   <= HEIGHT_RESET;
      edge_threshold_r <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_IMAGE_WIDTH:    image_width_r    <= DIM_W'(cfg_wdata);
        REG_IMAGE_HEIGHT:   image_height_r   <= DIM_W'(cfg_wdata);
        REG_EDGE_THRESHOLD: edge_threshold_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  sed_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .in_push      (in_push),
    .in_pixel     (in_pixel),
    .in_full      (in_full),
    .wq_push      (wq_push),
    .wq_data      (wq_din),
    .wq_full      (wq_full)
  );

  sed_win_fifo u_win_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (wq_push),
    .din   (wq_din),
    .full  (wq_full),
    .pop   (wq_pop),
    .dout  (wq_dout),
    .empty (wq_empty)
  );

  sed_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .edge_threshold (edge_threshold_r),
    .wq_empty       (wq_empty),
    .wq_dout        (wq_dout),
    .wq_pop         (wq_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_grad_x     (out_grad_x),
    .out_grad_y     (out_grad_y),
    .out_edge_res   (out_edge_res),
    .out_frame_end  (out_frame_end)
  );

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Sobel edge detector. Raster pixels are pushed
// with random gaps while results are popped with random stalls. A built-in
// line-store and window model predicts every gradient result, and each popped
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import sed_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 350;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 600;

  typedef enum int {
    PAT_NOISE,
    PAT_BINARY,
    PAT_FLAT,
    PAT_COLUMNS,
    PAT_ROWS
  } pattern_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_push   = 1'b0;
  pix_t                  in_pixel  = '0;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop   = 1'b0;
  pix_t                  out_grad_x;
  pix_t                  out_grad_y;
  logic                  out_edge_res;
  logic                  out_frame_end;

  sobel_edge_detector dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_pixel      (in_pixel),
    .in_full       (in_full),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_grad_x    (out_grad_x),
    .out_grad_y    (out_grad_y),
    .out_edge_res  (out_edge_res),
    .out_frame_end (out_frame_end)
  );

  // Model of the line stores, the window and the raster counters.
  pix_t             upper_line [MAX_WIDTH];
  pix_t             middle_line [MAX_WIDTH];
  pix_t             win [6];
  int               col_pos = 0;
  int               row_pos = 0;
  logic [DIM_W-1:0] width_reg  = WIDTH_RESET;
  logic [DIM_W-1:0] height_reg = HEIGHT_RESET;
  logic [THR_W-1:0] thr_reg    = THR_RESET;
  res_t             expected_grads [$];
  res_t             popped_want;

  int items_sent      = 0;
  int results_checked = 0;
  int frames_done     = 0;
  int error_count     = 0;

  bit send_idle = 1'b1;
  bit pop_idle  = 1'b1;
  int hold_requests = 0;
  int holds_taken   = 0;
  int hold_left     = 0;
  int pop_wait      = 0;
  int flat_level    = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic pix_t clamp_pix(input int s);
    if (s < 0) return 8'd0;
    if (s > 255) return 8'd255;
    return pix_t'(s);
  endfunction

  task automatic predict_gradients(input pix_t px);
    int w, h, idx, up, mid, bot, ul, ml, bl, um, bm, sx, sy;
    bit row_last, frame_last;
    res_t r;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    idx = col_pos % MAX_WIDTH;
    up  = upper_line[idx];
    mid = middle_line[idx];
    bot = px;
    row_last   = (col_pos >= w - 1);
    frame_last = row_last && (row_pos >= h - 1);
    if (row_pos >= 2 && col_pos >= 2) begin
      ul = win[0];
      ml = win[1];
      bl = win[2];
      um = win[3];
      bm = win[5];
      sx = (up - ul) + 2 * (mid - ml) + (bot - bl);
      sy = (bl + 2 * bm + bot) - (ul + 2 * um + up);
      r.grad_x    = clamp_pix(sx);
      r.grad_y    = clamp_pix(sy);
      r.edge_res  = (int'(r.grad_x) * int'(r.grad_x) + int'(r.grad_y) * int'(r.grad_y)) >
                    (int'(thr_reg) * int'(thr_reg));
      r.frame_end = frame_last;
      expected_grads.push_back(r);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = pix_t'(up);
    win[4] = pix_t'(mid);
    win[5] = px;
    upper_line[idx]  = pix_t'(mid);
    middle_line[idx] = px;
    if (row_last) begin
      col_pos = 0;
      row_pos = frame_last ? 0 : row_pos + 1;
      if (frame_last) frames_done++;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  function automatic pix_t next_pixel(input pattern_t pat);
    case (pat)
      PAT_BINARY:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PAT_FLAT:    return pix_t'(flat_level + $urandom_range(0, 3));
      PAT_COLUMNS: return (col_pos % 5 < 2) ? pix_t'($urandom_range(240, 255))
                                            : pix_t'($urandom_range(0, 15));
      PAT_ROWS:    return (row_pos % 4 < 2) ? 8'hF0 : 8'h0F;
      default:     return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends one pixel, after a random gap while send_idle is set, and returns at the edge that takes it.
  task automatic send_pixel(input pix_t px);
    int gap;
    gap = send_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push  <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (in_full);
    predict_gradients(px);
    items_sent++;
  endtask

  task automatic send_rest_of_frame(input pattern_t pat);
    do begin
      send_pixel(next_pixel(pat));
    end while (col_pos != 0 || row_pos != 0);
  endtask

  // Nine pixels in raster order, most significant byte first.
  task automatic send_square(input logic [71:0] img);
    for (int k = 0; k < 9; k++) send_pixel(img[71 - 8 * k -: 8]);
  endtask

  // Waits until every predicted result has been popped and the pipeline is
  // quiet, since pixels on border positions leave no trace in the queue.
  task automatic settle();
    in_push <= 1'b0;
    while (expected_grads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:    width_reg  = val[DIM_W-1:0];
      REG_IMAGE_HEIGHT:   height_reg = val[DIM_W-1:0];
      REG_EDGE_THRESHOLD: thr_reg    = val[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int w, input int h, input int t);
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_EDGE_THRESHOLD, CFG_DATA_W'(t));
    cfg_we <= 1'b0;
  endtask

  // Changes the image size only, leaving the threshold as it is.
  task automatic resize(input int w, input int h);
    settle();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    cfg_we <= 1'b0;
  endtask

  // A stretch of the first row at the reset width must not end the row; the
  // frame is then shrunk in mid row and finished at the reset threshold.
  task automatic test_reset_values();
    repeat (24) send_pixel(next_pixel(PAT_NOISE));
    resize(3, 3);
    send_rest_of_frame(PAT_NOISE);
  endtask

  task automatic test_extreme_windows();
    // Width and height below range fall back to three.
    configure(0, 1, 360);
    send_square(72'h00_00_00_00_00_FF_00_FF_FF);
    // Both sums saturate, and a threshold of 361 is just out of reach.
    configure(3, 3, 361);
    send_square(72'h00_00_00_00_00_FF_00_FF_FF);
    // Negative sums are forced to zero; zero magnitude never beats zero.
    configure(3, 3, 0);
    send_square(72'hFF_FF_FF_FF_FF_00_FF_00_00);
  endtask

  // Sizes beyond range must not end a row early; the frame is then cut down
  // to 64 columns and three rows in mid row.
  task automatic test_widest_rows();
    configure(4095, 4095, $urandom_range(0, 361));
    repeat (63) send_pixel(next_pixel(PAT_NOISE));
    resize(64, 3);
    send_rest_of_frame(PAT_NOISE);
  endtask

  // Forty rows at a height beyond range, then the frame is ended in mid frame.
  task automatic test_tallest_frame();
    configure(3, 4095, $urandom_range(0, 361));
    repeat (3 * 40) send_pixel(next_pixel(PAT_COLUMNS));
    resize(3, 3);
    send_rest_of_frame(PAT_COLUMNS);
  endtask

  // The result side stops for a long stretch while pixels keep coming.
  task automatic test_output_stall();
    configure(16, 12, 100);
    send_idle = 1'b0;
    hold_requests++;
    send_rest_of_frame(PAT_NOISE);
    send_idle = 1'b1;
  endtask

  task automatic test_random_frames();
    int start, w, h, t, pick;
    pattern_t pat;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      w = (pick == 0) ? $urandom_range(0, 2) :
          (pick == 1) ? $urandom_range(13, 40) : $urandom_range(3, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      pick = $urandom_range(0, 9);
      t = (pick < 5) ? $urandom_range(0, 200) :
          (pick < 7) ? $urandom_range(200, 361) :
          (pick == 7) ? ($urandom_range(0, 1) ? 0 : 511) : $urandom_range(0, 4095);
      send_idle  = ($urandom_range(0, 3) != 0);
      pop_idle   = ($urandom_range(0, 3) != 0);
      flat_level = $urandom_range(0, 252);
      pat = pattern_t'($urandom_range(0, 4));
      configure(w, h, t);
      // Now and then a frame is cut short and the next setting lands in it.
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 2 * eff_dim(width_reg, MAX_WIDTH)))
          send_pixel(next_pixel(pat));
      end else begin
        send_rest_of_frame(pat);
      end
    end
    send_idle = 1'b1;
    pop_idle  = 1'b1;
  endtask

  // Result side: a random wait before each pop while pop_idle is set, or a long requested hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_wait = 0;
      hold_left = 0;
    end else begin
      if (holds_taken != hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_taken = hold_requests;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (out_pop && !out_empty) begin
        pop_wait = pop_idle ? $urandom_range(0, 7) : 0;
        if (pop_wait == 0) begin
          out_pop <= 1'b1;
        end else begin
          out_pop <= 1'b0;
          pop_wait--;
        end
      end else if (!out_pop) begin
        if (pop_wait == 0) out_pop <= 1'b1;
        else pop_wait--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      results_checked++;
      if (expected_grads.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: gx=%0d gy=%0d edge=%0b end=%0b",
                   out_grad_x, out_grad_y, out_edge_res, out_frame_end);
      end else begin
        popped_want = expected_grads.pop_front();
        if (out_grad_x !== popped_want.grad_x || out_grad_y !== popped_want.grad_y ||
            out_edge_res !== popped_want.edge_res ||
            out_frame_end !== popped_want.frame_end) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("result %0d: expected gx=%0d gy=%0d edge=%0b end=%0b,",
                     results_checked, popped_want.grad_x, popped_want.grad_y,
                     popped_want.edge_res, popped_want.frame_end,
                     " got gx=%0d gy=%0d edge=%0b end=%0b",
                     out_grad_x, out_grad_y, out_edge_res, out_frame_end);
        end
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles with %0d results outstanding",
             LIMIT_CYCLES, expected_grads.size());
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_extreme_windows();
    test_widest_rows();
    test_tallest_frame();
    test_output_stall();
    test_random_frames();
    settle();
    $display("covered %0d pixels over %0d frames: reset sizes, sizes out of range,",
             items_sent, frames_done);
    $display("mid-frame resizes, a long output stall; %0d results checked, %0d errors",
             results_checked, error_count);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/sed_pkg.sv
sv/sed_front.sv
sv/sed_win_fifo.sv
sv/sed_back.sv
sv/sobel_edge_detector.sv
tb/sv/testbench.sv
